FILE: rtl/lnbs_pkg.sv
// ----------------------------------------------------------------------------
// lnbs_pkg: shared types and constants of the LCD nibble bus sequencer
// Holds the request and result structures, the queued command record, the
// register indexes, the expander bit layout and the beat decode function.
// ----------------------------------------------------------------------------
package lnbs_pkg;

	// Request modes.
	localparam logic [1:0] MODE_CMD   = 2'd0;
	localparam logic [1:0] MODE_DATA  = 2'd1;
	localparam logic [1:0] MODE_POLL  = 2'd2;
	localparam logic [1:0] MODE_REPLY = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_BACKLIGHT  = 1'b0;
	localparam logic CFG_POLL_LIMIT = 1'b1;

	// Expander byte layout: data nibble in bits 7..4, then backlight, enable,
	// read/write and register select.
	localparam logic [7:0] BIT_RS  = 8'h01;
	localparam logic [7:0] BIT_RW  = 8'h02;
	localparam logic [7:0] BIT_EN  = 8'h04;
	localparam logic [7:0] BIT_BL  = 8'h08;
	localparam logic [7:0] MASK_HI = 8'hF0;
	localparam logic [7:0] MASK_LO = 8'h0F;

	localparam logic [7:0] POLL_LIMIT_RESET = 8'd20;
	localparam logic [6:0] ROW_SPLIT        = 7'd40;
	localparam logic [7:0] ROW1_OFFSET      = 8'd64;
	localparam logic [7:0] POLL_COUNT_MAX   = 8'd255;

	typedef enum logic [1:0] {
		ST_READY   = 2'd0,
		ST_WAIT    = 2'd1,
		ST_TIMEOUT = 2'd2
	} wait_state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] value;
		logic       check_busy;
		logic [7:0] read_high;
		logic [7:0] read_low;
	} lnbs_in_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] expander_byte;
		logic       read_point;
		logic       last;
		logic       busy_res;
		logic [6:0] address;
		logic       cursor_row;
		logic [7:0] cursor_col;
		logic [1:0] status;
	} lnbs_out_t;

	// Classified request as it waits in the queue: what to emit, plus the
	// state that every result of this request reports.
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] value;
		logic       backlight;
		logic       busy;
		logic [6:0] address;
		logic       row;
		logic [7:0] col;
		logic [1:0] status;
	} lnbs_cmd_t;

	// Result of one beat of a queued command.
	function automatic lnbs_out_t lnbs_beat(input lnbs_cmd_t c, input logic [2:0] beat);
		lnbs_out_t  r;
		logic [2:0] idx;
		logic [7:0] bl;
		logic [7:0] rs;
		logic [7:0] nib;
		logic [7:0] rd;
		r.busy_res      = c.busy;
		r.address       = c.address;
		r.cursor_row    = c.row;
		r.cursor_col    = c.col;
		r.status        = c.status;
		r.has_byte      = 1'b1;
		r.expander_byte = 8'h00;
		r.read_point    = 1'b0;
		r.last          = 1'b0;
		bl  = c.backlight ? BIT_BL : 8'h00;
		rs  = (c.mode == MODE_DATA) ? BIT_RS : 8'h00;
		idx = (c.mode == MODE_DATA) ? (beat - 3'd1) : beat;
		nib = idx[1] ? {c.value[3:0], 4'h0} : (c.value & MASK_HI);
		rd  = MASK_HI | bl | BIT_RW;
		case (c.mode)
			MODE_CMD, MODE_DATA: begin
				if (c.mode == MODE_DATA && beat == 3'd0) begin
					r.expander_byte = bl | rs;
				end else begin
					r.expander_byte = nib | bl | rs | (idx[0] ? 8'h00 : BIT_EN);
				end
				r.last = (idx == 3'd3);
			end
			MODE_POLL: begin
				r.expander_byte = rd | (beat[0] ? BIT_EN : 8'h00);
				r.read_point    = beat[0];
				r.last          = (beat == 3'd4);
			end
			default: begin
				r.has_byte = 1'b0;
				r.last     = 1'b1;
			end
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/lnbs_front.sv
// ----------------------------------------------------------------------------
// lnbs_front: request intake and display state tracking
// Accepts requests, applies them to the wait state, poll count and cursor
// registers, and pushes a command record into the queue.
// ----------------------------------------------------------------------------
module lnbs_front import lnbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_write,
	input  logic      cfg_index,
	input  logic [7:0] cfg_data,
	input  logic      in_valid,
	input  lnbs_in_t  in_data,
	input  logic      queue_full,
	output logic      push,
	output lnbs_cmd_t push_cmd
);

	logic        backlight_q;
	logic [7:0]  poll_limit_q;
	wait_state_t wait_q;
	logic [7:0]  poll_count_q;
	logic [6:0]  address_q;
	logic        row_q;
	logic [7:0]  col_q;
	logic        busy_q;

	wait_state_t wait_n;
	logic [7:0]  poll_count_n;
	logic [6:0]  address_n;
	logic        row_n;
	logic [7:0]  col_n;
	logic        busy_n;
	logic [7:0]  status_byte;
	logic [7:0]  poll_inc;

	assign push        = in_valid && !queue_full;
	assign status_byte = (in_data.read_high & MASK_HI) | ((in_data.read_low >> 4) & MASK_LO);
	assign poll_inc    = (poll_count_q == POLL_COUNT_MAX) ? poll_count_q : poll_count_q + 8'd1;

	always_comb begin
		wait_n       = wait_q;
		poll_count_n = poll_count_q;
		address_n    = address_q;
		row_n        = row_q;
		col_n        = col_q;
		busy_n       = busy_q;
		case (in_data.mode)
			MODE_CMD, MODE_DATA: begin
				wait_n       = in_data.check_busy ? ST_WAIT : ST_READY;
				poll_count_n = 8'd0;
			end
			MODE_POLL: begin
			end
			default: begin
				if (status_byte[7]) begin
					busy_n = 1'b1;
					if (wait_q != ST_TIMEOUT) begin
						poll_count_n = poll_inc;
						wait_n       = (poll_inc >= poll_limit_q) ? ST_TIMEOUT : ST_WAIT;
					end
				end else begin
					busy_n       = 1'b0;
					address_n    = status_byte[6:0];
					row_n        = (status_byte[6:0] >= ROW_SPLIT);
					col_n        = row_n ? ({1'b0, status_byte[6:0]} - ROW1_OFFSET)
						: {1'b0, status_byte[6:0]};
					wait_n       = ST_READY;
					poll_count_n = 8'd0;
				end
			end
		endcase
	end

	always_comb begin
		push_cmd.mode      = in_data.mode;
		push_cmd.value     = in_data.value;
		push_cmd.backlight = backlight_q;
		push_cmd.busy      = busy_n;
		push_cmd.address   = address_n;
		push_cmd.row       = row_n;
		push_cmd.col       = col_n;
		push_cmd.status    = wait_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q  <= 1'b1;
			poll_limit_q <= POLL_LIMIT_RESET;
			wait_q       <= ST_READY;
			poll_count_q <= 8'd0;
			address_q    <= 7'd0;
			row_q        <= 1'b0;
			col_q        <= 8'd0;
			busy_q       <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_BACKLIGHT:  backlight_q  <= cfg_data[0];
					CFG_POLL_LIMIT: poll_limit_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (push) begin
				wait_q       <= wait_n;
				poll_count_q <= poll_count_n;
				address_q    <= address_n;
				row_q        <= row_n;
				col_q        <= col_n;
				busy_q       <= busy_n;
			end
		end
	end

	// A timeout is only reached after at least one counted busy reply.
	assert property (@(posedge clk) disable iff (!arst_n)
		(wait_q == ST_TIMEOUT) |-> (poll_count_q != 8'd0))
		else $error("timeout with zero poll count");

endmodule

FILE: rtl/lnbs_queue.sv
// ----------------------------------------------------------------------------
// lnbs_queue: command queue between intake and sequencer
// A small register queue that lets the intake and the byte sequencer stall
// independently of each other.
// ----------------------------------------------------------------------------
module lnbs_queue import lnbs_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lnbs_cmd_t push_cmd,
	input  logic      pop,
	output logic      full,
	output logic      empty,
	output lnbs_cmd_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lnbs_cmd_t         mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy beyond depth");

endmodule

FILE: rtl/lnbs_back.sv
// ----------------------------------------------------------------------------
// lnbs_back: expander byte sequencer
// Steps through the beats of the command at the head of the queue, one
// result per cycle while out_stall is low, into the output register.
// ----------------------------------------------------------------------------
module lnbs_back import lnbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  lnbs_cmd_t head,
	output logic      pop,
	input  logic      out_stall,
	output logic      out_valid,
	output lnbs_out_t out_data
);

	logic [2:0] beat_q;
	logic       out_valid_q;
	lnbs_out_t  out_q;
	lnbs_out_t  beat_res;
	logic       load;

	assign beat_res  = lnbs_beat(head, beat_q);
	assign load      = head_valid && (!out_valid_q || !out_stall);
	assign pop       = load && beat_res.last;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= beat_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				beat_q <= 3'd0;
			end else if (load) begin
				beat_q <= beat_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A beat in progress belongs to a command still held at the queue head.
	assert property (@(posedge clk) disable iff (!arst_n)
		(beat_q != 3'd0) |-> head_valid)
		else $error("beat count running with empty queue");

	// A result without a byte is only ever a status reply, which ends its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.has_byte) |-> out_q.last)
		else $error("byteless result not last");

	// Read points fall on strobes with the enable bit set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.read_point) |->
		(out_q.has_byte && ((out_q.expander_byte & BIT_EN) != 8'h00)))
		else $error("read point without enable strobe");

endmodule

FILE: rtl/lcd_nibble_bus_sequencer_unit.sv
// ----------------------------------------------------------------------------
// lcd_nibble_bus_sequencer_unit: character LCD 4-bit bus sequencer
// Turns display requests into expander bytes and tracks busy and cursor state.
// ----------------------------------------------------------------------------
// A request is a command write, a data write, a status poll or a status reply.
// The intake applies each request to the display state (wait status, poll
// count, address and cursor) as soon as it is accepted and places a command
// record in a queue of QUEUE_DEPTH entries; the sequencer then emits the
// request's results at one per cycle while out_stall is low, through a
// registered output. A command write gives four results, a data write and
// a poll five each, and a reply one, counted by the sequencer's beat
// counter. The intake takes a request in every cycle while the queue has
// room, and raises in_stall only when it is full. Every result
// of one request carries the state as it stands after that request, and the
// final result of each request is marked by last. Configuration writes apply
// at once; they are meant to be made while no request is in flight.
module lcd_nibble_bus_sequencer_unit import lnbs_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_write,
	input  logic      cfg_index,
	input  logic [7:0] cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  lnbs_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output lnbs_out_t out_data
);

	logic      push;
	lnbs_cmd_t push_cmd;
	logic      pop;
	logic      queue_full;
	logic      queue_empty;
	lnbs_cmd_t head;

	// The intake holds off only when the queue cannot take another record.
	assign in_stall = queue_full;

	lnbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	lnbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (queue_full),
		.empty    (queue_empty),
		.head     (head)
	);

	lnbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!queue_empty),
		.head       (head),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

endmodule
